### rtl/core/rcidr_pkg.sv
// shared types, step codes and microcode table for the range to cidr splitter
package rcidr_pkg;

  typedef logic [1:0] step_t;

  localparam step_t STEP_IDLE = 2'd0;
  localparam step_t STEP_REM  = 2'd1;
  localparam step_t STEP_SIZE = 2'd2;
  localparam step_t STEP_EMIT = 2'd3;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  typedef enum logic [1:0] {
    BR_NONE,
    BR_ERR,
    BR_MORE
  } branch_t;

  typedef struct packed {
    logic    take_in;
    logic    calc_rem;
    logic    calc_size;
    logic    emit;
    wait_t   hold;
    branch_t br;
    step_t   target;
  } uc_word_t;

  // a held step stays put; otherwise a branch taken goes to target, else the step counter advances (wraps)
  function automatic uc_word_t uc_rom(input step_t step);
    uc_word_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.hold    = WAIT_IN;
        w.br      = BR_ERR;
        w.target  = STEP_EMIT;
      end
      STEP_REM: begin
        w.calc_rem = 1'b1;
        w.hold     = WAIT_NONE;
        w.br       = BR_NONE;
        w.target   = STEP_IDLE;
      end
      STEP_SIZE: begin
        w.calc_size = 1'b1;
        w.hold      = WAIT_NONE;
        w.br        = BR_NONE;
        w.target    = STEP_IDLE;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.hold   = WAIT_OUT;
        w.br     = BR_MORE;
        w.target = STEP_REM;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/rcidr_if.sv
// item channels: address ranges in, cidr blocks out
interface rcidr_range_if;
  logic        valid;
  logic        ready;
  logic [31:0] range_first;
  logic [31:0] range_last;

  modport source (output valid, output range_first, output range_last, input ready);
  modport sink (input valid, input range_first, input range_last, output ready);
endinterface

interface rcidr_block_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [5:0]  prefix_length;
  logic        final_block;
  logic        range_error;

  modport source (
    output valid, output block_address, output prefix_length,
    output final_block, output range_error, input ready
  );
  modport sink (
    input valid, input block_address, input prefix_length,
    input final_block, input range_error, output ready
  );
endinterface

### rtl/core/rcidr_size.sv
// largest aligned block at the cursor that fits the remaining count
module rcidr_size #(
  parameter int ADDRESS_BITS = 32
) (
  input  logic [ADDRESS_BITS-1:0] cur,
  input  logic [ADDRESS_BITS:0]   rem,
  output logic [ADDRESS_BITS:0]   size,
  output logic [5:0]              size_log2,
  output logic                    last_one
);

  localparam int SmearSteps = $clog2(ADDRESS_BITS + 1);

  logic [ADDRESS_BITS:0] smear;
  logic [ADDRESS_BITS:0] lim;
  logic [ADDRESS_BITS:0] low;

  // highest power of two not above rem
  always_comb begin
    smear = rem;
    for (int i = 0; i < SmearSteps; i++) begin
      smear = smear | (smear >> (1 << i));
    end
    lim = smear ^ (smear >> 1);
  end

  // alignment of the cursor; zero is aligned to the whole space
  always_comb begin
    if (cur == '0) begin
      low = {1'b1, {ADDRESS_BITS{1'b0}}};
    end else begin
      low = {1'b0, cur & (~cur + 1'b1)};
    end
  end

  assign size = (low < lim) ? low : lim;

  always_comb begin
    size_log2 = '0;
    for (int i = 0; i <= ADDRESS_BITS; i++) begin
      if (size[i]) begin
        size_log2 = size_log2 | 6'(i);
      end
    end
  end

  assign last_one = (size == rem);

endmodule

### rtl/core/ipv4_range_to_cidr_blocks.sv
// top level: splits an address range into its minimal list of cidr blocks
//
// ranges: takes one item holding range_first and range_last (inclusive);
//   only the low ADDRESS_BITS bits of each are used.
// blocks: gives one item per cidr block in ascending address order, with
//   block_address, prefix_length and final_block set on the last one.
//   a range whose first address is above its last gives a single item
//   with range_error set and every other field zero.
// control is a four-step microcode table walked by a step counter:
//   idle/load, remaining count, block size, emit. each block passes
//   through the remaining count, size search and emit steps, and a range
//   needs at most 62 blocks at 32 address bits; an error range goes from
//   idle straight to emit and back to idle. the first block is loaded into
//   the output register in the emit step, after the remaining count and size steps.
// one range is worked at a time; ranges.ready is high only in the idle step.
// the emit step holds while the output register is full and not taken,
//   so a stalled receiver simply freezes the sequence; nothing is dropped.
// rst is synchronous: the step counter returns to idle and the output
//   register is emptied.
module ipv4_range_to_cidr_blocks
  import rcidr_pkg::*;
#(
  parameter int ADDRESS_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  rcidr_range_if.sink          ranges,
  rcidr_block_if.source        blocks
);

  // sequencer state
  step_t    step;
  step_t    step_next;
  uc_word_t uc;

  // datapath registers
  logic [ADDRESS_BITS-1:0] cursor;
  logic [ADDRESS_BITS-1:0] last;
  logic [ADDRESS_BITS:0]   rem;
  logic [ADDRESS_BITS:0]   size;
  logic [5:0]              size_log2;
  logic                    fin;
  logic                    err;

  // size unit outputs
  logic [ADDRESS_BITS:0] size_c;
  logic [5:0]            size_log2_c;
  logic                  fin_c;

  // output register
  logic        out_valid;
  logic [31:0] out_address;
  logic [5:0]  out_prefix;
  logic        out_final;
  logic        out_error;

  logic [ADDRESS_BITS-1:0] first_in;
  logic [ADDRESS_BITS-1:0] last_in;
  logic                    accept;
  logic                    slot_free;
  logic                    stall;
  logic                    taken;

  assign uc = uc_rom(step);

  assign first_in  = ranges.range_first[ADDRESS_BITS-1:0];
  assign last_in   = ranges.range_last[ADDRESS_BITS-1:0];
  assign ranges.ready = uc.take_in;
  assign accept    = ranges.valid && uc.take_in;
  assign slot_free = !out_valid || blocks.ready;

  // hold the current step until its wait condition clears
  always_comb begin
    unique case (uc.hold)
      WAIT_IN:  stall = !accept;
      WAIT_OUT: stall = !slot_free;
      default:  stall = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uc.br)
      BR_ERR:  taken = (first_in > last_in);
      BR_MORE: taken = !(fin || err);
      default: taken = 1'b0;
    endcase
    if (stall) begin
      step_next = step;
    end else if (taken) begin
      step_next = uc.target;
    end else begin
      step_next = step + 2'd1;
    end
  end

  rcidr_size #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_size (
    .cur       (cursor),
    .rem       (rem),
    .size      (size_c),
    .size_log2 (size_log2_c),
    .last_one  (fin_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_IDLE;
      out_valid <= 1'b0;
      err       <= 1'b0;
    end else begin
      step <= step_next;

      if (accept) begin
        cursor <= first_in;
        last   <= last_in;
        err    <= (first_in > last_in);
      end

      // count of addresses still to cover, one bit wider for the full space
      if (uc.calc_rem) begin
        rem <= {1'b0, last} - {1'b0, cursor} + 1'b1;
      end

      if (uc.calc_size) begin
        size      <= size_c;
        size_log2 <= size_log2_c;
        fin       <= fin_c;
      end

      if (uc.emit && slot_free) begin
        out_valid <= 1'b1;
        if (err) begin
          out_address <= '0;
          out_prefix  <= '0;
          out_final   <= 1'b0;
          out_error   <= 1'b1;
        end else begin
          out_address <= 32'(cursor);
          out_prefix  <= 6'(ADDRESS_BITS) - size_log2;
          out_final   <= fin;
          out_error   <= 1'b0;
        end
        cursor <= cursor + size[ADDRESS_BITS-1:0];
      end else if (blocks.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign blocks.valid         = out_valid;
  assign blocks.block_address = out_address;
  assign blocks.prefix_length = out_prefix;
  assign blocks.final_block   = out_final;
  assign blocks.range_error   = out_error;

`ifndef ASSERT_OFF
  // an error item carries nothing but the error flag
  assert property (@(posedge clk) disable iff (rst)
    blocks.valid && blocks.range_error |->
      blocks.block_address == '0 && blocks.prefix_length == '0 && !blocks.final_block)
    else $error("error item with nonzero fields");

  // prefix never exceeds the address width
  assert property (@(posedge clk) disable iff (rst)
    blocks.valid |-> blocks.prefix_length <= 6'(ADDRESS_BITS))
    else $error("prefix length out of range");

  // an inverted range goes straight to the emit step
  assert property (@(posedge clk) disable iff (rst)
    accept && (first_in > last_in) |=> step == STEP_EMIT)
    else $error("inverted range not sent to emit");

  // a block is loaded only after its size was computed for the current cursor
  assert property (@(posedge clk) disable iff (rst)
    uc.emit && slot_free && !err |-> $past(step) == STEP_SIZE || $past(step) == STEP_EMIT)
    else $error("emit without size step");
`endif

endmodule
